[hdl/lbue_pkg.sv]
package lbue_pkg;

	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] CR_CODE = 8'h0D;
	localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	localparam int QDEPTH = 4;
	localparam int QPW = $clog2(QDEPTH);

	typedef struct packed {
		logic is_cr;
		logic [CHAR_W-1:0] chr;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_ECHO
	} back_state_t;

	function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

[hdl/lbue_ram.sv]
module lbue_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[hdl/lbue_front.sv]
module lbue_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [lbue_pkg::CHAR_W-1:0] in_char,
	output logic                       cmd_valid,
	output lbue_pkg::cmd_t             cmd,
	input  logic                       cmd_pop
);

	import lbue_pkg::*;

	cmd_t           q_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;
	cmd_t           new_cmd;

	assign full      = (cnt_q == (QPW+1)'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_comb begin
		new_cmd.is_cr = (in_char == CR_CODE);
		new_cmd.chr   = in_char;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/lbue_back.sv]
module lbue_back #(
	parameter int LINE_CHARS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  lbue_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [lbue_pkg::CHAR_W-1:0] out_char,
	output logic                       last_of_line
);

	import lbue_pkg::*;

	localparam int CW = $clog2(LINE_CHARS + 1);
	localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     len_q;
	logic              pend_s1;
	logic              pend_last_s1;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [CHAR_W-1:0] ram_rdata;
	logic              rd_issue;
	logic              room;
	logic              is_last;
	logic              has_space;

	logic [CHAR_W-1:0] ob_char_q [2];
	logic              ob_last_q [2];
	logic              ob_wr_q;
	logic              ob_rd_q;
	logic [1:0]        ob_occ_q;
	logic              ob_pop;

	assign has_space = (cnt_q < CW'(LINE_CHARS));
	assign is_last   = ((idx_q + 1'b1) == len_q);
	assign ob_pop    = pop && !empty;
	assign room      = ({1'b0, ob_occ_q} + {2'b00, pend_s1}) <= (3'd1 + {2'b00, ob_pop});

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd.is_cr && cnt_q != '0) begin
					state_d = BK_ECHO;
				end
			end
			BK_ECHO: begin
				if (rd_issue && is_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		ram_we   = 1'b0;
		rd_issue = 1'b0;
		ram_addr = cnt_q[AW-1:0];
		case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
				ram_we  = cmd_valid && !cmd.is_cr && has_space;
			end
			BK_ECHO: begin
				rd_issue = room;
				ram_addr = idx_q[AW-1:0];
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	lbue_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_CHARS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(cmd.chr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			len_q        <= '0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_s1      <= rd_issue;
			pend_last_s1 <= rd_issue && is_last;
			if (state_q == BK_IDLE && cmd_valid) begin
				if (cmd.is_cr) begin
					len_q <= cnt_q;
					idx_q <= '0;
					cnt_q <= '0;
				end else if (has_space) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (rd_issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			ob_char_q[ob_wr_q] <= to_upper(ram_rdata);
			ob_last_q[ob_wr_q] <= pend_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_occ_q <= '0;
		end else begin
			if (pend_s1) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			if (pend_s1 && !ob_pop) begin
				ob_occ_q <= ob_occ_q + 1'b1;
			end else if (!pend_s1 && ob_pop) begin
				ob_occ_q <= ob_occ_q - 1'b1;
			end
		end
	end

	assign empty        = (ob_occ_q == '0);
	assign out_char     = ob_char_q[ob_rd_q];
	assign last_of_line = ob_last_q[ob_rd_q];

endmodule

[hdl/line_buffer_uppercase_echo.sv]
// A line echo runs through the echo state, the registered store read and the output buffer.
// Throughput: the input queue takes one request per cycle while not full and the line store absorbs one
// character per cycle while idle; an echo delivers one character per cycle while pop is held.
// Input requests wait in the four-entry command queue while a line is being echoed.
// Reset clears the queues, the character count and the control state; the store is not cleared.
module line_buffer_uppercase_echo #(
	parameter int LINE_CHARS = 63
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [lbue_pkg::CHAR_W-1:0] in_char,
	output logic                       empty,
	input  logic                       pop,
	output logic [lbue_pkg::CHAR_W-1:0] out_char,
	output logic                       last_of_line
);

	import lbue_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	lbue_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_char  (in_char),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	lbue_back #(
		.LINE_CHARS(LINE_CHARS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.last_of_line(last_of_line)
	);

endmodule

[hdl/lbue_chk.sv]
module lbue_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input logic [lbue_pkg::CHAR_W-1:0] out_char,
	input logic                       last_of_line
);

	import lbue_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_char) && $stable(last_of_line))
		else $error("result changed while stalled");

	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_char >= LOWER_A && out_char <= LOWER_Z))
		else $error("lowercase letter echoed");

	a_no_cr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_char != CR_CODE)
		else $error("carriage return echoed");

	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("queue filled without a request");

endmodule

bind line_buffer_uppercase_echo lbue_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.out_char    (out_char),
	.last_of_line(last_of_line)
);

[tb/lbue_checker.sv]
module lbue_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        full,
	input  logic [lbue_pkg::CHAR_W-1:0] in_char,
	input  logic                        empty,
	input  logic                        pop,
	input  logic [lbue_pkg::CHAR_W-1:0] out_char,
	input  logic                        last_of_line,
	output int                          fail_count,
	output int                          echoes_owed,
	output int                          echoes_seen,
	output int                          bytes_dropped
);
	import lbue_pkg::*;

	localparam int LINE_LEN = 63;

	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              last;
	} echo_t;

	echo_t             echo_due[$];
	echo_t             head;
	logic [CHAR_W-1:0] line_mem [LINE_LEN];
	int                line_fill;
	int                k;

	function automatic logic [CHAR_W-1:0] raise_case(input logic [CHAR_W-1:0] c);
		if (c >= LOWER_A && c <= LOWER_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	initial begin
		fail_count = 0;
		echoes_owed = 0;
		echoes_seen = 0;
		bytes_dropped = 0;
		line_fill = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_fill = 0;
			echo_due.delete();
			echoes_owed = 0;
		end else begin
			// A result can only stem from a carriage return taken at an earlier edge.
			if (pop && !empty) begin
				echoes_seen++;
				if (echo_due.size() == 0) begin
					$error("out_char: no echo expected, actual %h", out_char);
					fail_count++;
				end else begin
					head = echo_due.pop_front();
					if (out_char !== head.chr) begin
						$error("out_char: expected %h, actual %h", head.chr, out_char);
						fail_count++;
					end
					if (last_of_line !== head.last) begin
						$error("last_of_line: expected %b, actual %b", head.last,
							last_of_line);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				if (in_char == CR_CODE) begin
					for (k = 0; k < line_fill; k++) begin
						echo_due.push_back('{chr: raise_case(line_mem[k]),
							last: (k == line_fill - 1)});
					end
					line_fill = 0;
				end else if (line_fill < LINE_LEN) begin
					line_mem[line_fill] = in_char;
					line_fill++;
				end else begin
					bytes_dropped++;
				end
			end
			echoes_owed = echo_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
module tb_top;
	import lbue_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 180;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [CHAR_W-1:0] in_char;
	logic              empty;
	logic              pop;
	logic [CHAR_W-1:0] out_char;
	logic              last_of_line;

	int fail_count;
	int echoes_owed;
	int echoes_seen;
	int bytes_dropped;
	int chars_sent;
	int lines_sent;
	int idle_cycles;
	int pop_hold;
	bit no_gaps;

	line_buffer_uppercase_echo u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_char      (in_char),
		.empty        (empty),
		.pop          (pop),
		.out_char     (out_char),
		.last_of_line (last_of_line)
	);

	lbue_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_char       (in_char),
		.empty         (empty),
		.pop           (pop),
		.out_char      (out_char),
		.last_of_line  (last_of_line),
		.fail_count    (fail_count),
		.echoes_owed   (echoes_owed),
		.echoes_seen   (echoes_seen),
		.bytes_dropped (bytes_dropped)
	);

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char();
		logic [CHAR_W-1:0] c;
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			c = LOWER_A + CHAR_W'($urandom_range(0, 25));
		end else if (r < 6) begin
			c = 8'h40 + CHAR_W'($urandom_range(0, 63));
		end else begin
			c = CHAR_W'($urandom_range(0, 255));
		end
		if (c == CR_CODE) begin
			c = 8'h0E;
		end
		return c;
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] c);
		int gap;
		gap = next_gap();
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
			in_char <= CHAR_W'($urandom_range(0, 255));
		end
		@(negedge clk);
		push <= 1'b1;
		in_char <= c;
		do begin
			@(posedge clk);
		end while (full);
		chars_sent++;
		if (c == CR_CODE) begin
			lines_sent++;
		end
	endtask

	task automatic send_line(input int len);
		no_gaps = ($urandom_range(0, 4) == 0);
		repeat (len) begin
			send_char(pick_char());
		end
		send_char(CR_CODE);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (echoes_owed != 0) begin
			@(negedge clk);
		end
	endtask

	// Result side: runs of pop held high broken by random stalls.
	initial begin
		pop = 1'b0;
		pop_hold = 0;
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					pop_hold = next_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [CHAR_W-1:0] edge_chars [12];
		int r;
		int len;
		arst_n = 1'b0;
		push = 1'b0;
		in_char = '0;
		chars_sent = 0;
		lines_sent = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		edge_chars = '{8'h00, 8'hFF, 8'h60, 8'h61, 8'h7A, 8'h7B,
			8'h40, 8'h41, 8'h5A, 8'h5B, 8'h0C, 8'h0E};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty line, one-character line, then the case-mapping boundaries.
		send_char(CR_CODE);
		send_char(8'h61);
		send_char(CR_CODE);
		foreach (edge_chars[i]) begin
			send_char(edge_chars[i]);
		end
		send_char(CR_CODE);
		send_char(CR_CODE);
		wait_drained();

		// A line longer than the store, so the tail bytes are dropped.
		send_line(66);

		while (chars_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				repeat ($urandom_range(1, 5)) begin
					send_char(CHAR_W'($urandom_range(0, 255)));
				end
			end else begin
				if (r < 18) begin
					len = 0;
				end else if (r < 94) begin
					len = $urandom_range(1, 12);
				end else begin
					len = $urandom_range(60, 70);
				end
				send_line(len);
			end
		end

		wait_drained();
		repeat (16) @(negedge clk);
		$display("Sent %0d characters closing %0d lines; %0d bytes dropped on a full line.",
			chars_sent, lines_sent, bytes_dropped);
		$display("Checked %0d echoed characters.", echoes_seen);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
